// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/hufd_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// hufd_pkg
// Types and constants shared by the code-tree decoder modules.
// ---------------------------------------------------------------------------
package hufd_pkg;

	localparam int NODE_COUNT_DEF      = 256;
	localparam int MAX_CODE_LENGTH_DEF = 16;

	localparam int SYM_W    = 8;   // symbol width
	localparam int BITS_W   = 16;  // code word field width
	localparam int LEN_IN_W = 5;   // code length field width
	localparam int CMD_W    = 2;
	localparam int S_DATA_W = 32;  // code_bits, code_length, symbol, zero fill

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DECODE = 2'd1,
		CMD_FLUSH  = 2'd2,
		CMD_IGNORE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WALK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;       // latch a new word
		logic load;        // take node contents into the work register
		logic follow;      // step to an existing child and read it
		logic alloc;       // create a child node
		logic store_leaf;  // mark current node with the symbol
		logic write_back;  // rewrite current node unchanged
		logic cur_to_root;
		logic cur_to_node;
		logic emit_sym;
		logic emit_err;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic len_zero;
		logic link_nz;
		logic full;
		logic holds;
		logic at_child;
		logic out_busy;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/hufd_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// hufd_ctrl
// Sequencer for insert, decode and flush walks over the node table.
// ---------------------------------------------------------------------------
module hufd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire hufd_pkg::cmd_t    command,
	output logic                   s_tready,
	input  wire hufd_pkg::dp_stat_t stat,
	output hufd_pkg::ctl_cmd_t     ctl
);
	import hufd_pkg::*;

	state_t state_q, state_d;
	logic   done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// outputs
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.start = s_tvalid && (command != CMD_IGNORE);
			end
			ST_LOAD: begin
				ctl.load = 1'b1;
			end
			ST_WALK: begin
				unique case (stat.cmd)
					CMD_INSERT: begin
						if (stat.len_zero) begin
							ctl.store_leaf = 1'b1;
						end else if (stat.link_nz) begin
							ctl.follow = 1'b1;
						end else if (stat.full) begin
							if (!stat.out_busy) begin
								ctl.write_back = 1'b1;
								ctl.emit_err   = 1'b1;
							end
						end else begin
							ctl.alloc = 1'b1;
						end
					end
					CMD_DECODE: begin
						if (!stat.at_child && stat.link_nz) begin
							ctl.follow = 1'b1;
						end else if (stat.at_child && !stat.holds) begin
							ctl.cur_to_node = 1'b1;
						end else if (!stat.holds) begin
							ctl.cur_to_root = 1'b1;
						end else if (!stat.out_busy) begin
							ctl.emit_sym    = 1'b1;
							ctl.cur_to_root = 1'b1;
						end
					end
					CMD_FLUSH: begin
						if (!stat.holds) begin
							ctl.cur_to_root = 1'b1;
						end else if (!stat.out_busy) begin
							ctl.emit_sym    = 1'b1;
							ctl.cur_to_root = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign done = ctl.store_leaf | ctl.write_back | ctl.cur_to_root | ctl.cur_to_node;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (stat.cmd == CMD_IGNORE) begin
					state_d = ST_IDLE;
				end else if (ctl.follow) begin
					state_d = ST_LOAD;
				end else if (done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ASSERT_NEXT(a_load_then_walk, state_q == ST_LOAD, state_q == ST_WALK)
	`ASSERT_IMPL(a_one_table_op, 1'b1, $onehot0({ctl.follow, ctl.alloc, ctl.store_leaf, ctl.write_back}))
	`ASSERT_IMPL(a_emit_finishes, ctl.emit_sym || ctl.emit_err, state_d == ST_IDLE)

endmodule
`default_nettype wire

// ----- sv/hufd_datapath.sv -----
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// hufd_datapath
// Node table, walk registers, allocation counter and result register.
// ---------------------------------------------------------------------------
module hufd_datapath #(
	parameter int NODE_COUNT      = hufd_pkg::NODE_COUNT_DEF,
	parameter int MAX_CODE_LENGTH = hufd_pkg::MAX_CODE_LENGTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire hufd_pkg::ctl_cmd_t        ctl,
	output hufd_pkg::dp_stat_t             stat,
	input  wire logic [hufd_pkg::S_DATA_W-1:0] s_tdata,
	input  wire hufd_pkg::cmd_t            command,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [hufd_pkg::SYM_W-1:0]     m_tdata,
	output logic                           m_tuser
);
	import hufd_pkg::*;

	localparam int NW     = $clog2(NODE_COUNT);
	localparam int LW     = $clog2(MAX_CODE_LENGTH + 1);
	localparam int WORD_W = 2 * NW + 1 + SYM_W;

	// table word: sym | holds | right | left
	logic [WORD_W-1:0] mem [NODE_COUNT];
	logic [WORD_W-1:0] rd_q;
	logic [NW-1:0]     rd_addr;

	// root kept in flops so reset clears it
	logic [NW-1:0]    root_left_q, root_right_q;
	logic             root_holds_q;
	logic [SYM_W-1:0] root_sym_q;

	// work register: contents of node_q
	logic [NW-1:0]    w_left_q, w_right_q;
	logic             w_holds_q;
	logic [SYM_W-1:0] w_sym_q;

	cmd_t             cmd_q;
	logic [BITS_W-1:0] bits_q;
	logic [LW-1:0]    len_q;
	logic [SYM_W-1:0] sym_q;
	logic             at_child_q;
	logic [NW-1:0]    node_q;
	logic [NW-1:0]    cur_node_q;
	logic [NW:0]      free_q;

	logic             out_valid_q;
	logic             out_err_q;
	logic [SYM_W-1:0] out_sym_q;

	logic [BITS_W-1:0]   in_bits;
	logic [LEN_IN_W-1:0] in_len;
	logic [SYM_W-1:0]    in_sym;
	logic [LW-1:0]       len_sat;
	logic [NW-1:0]       start_node;
	logic [NW-1:0]       link;
	logic [NW-1:0]       free_idx;
	logic                full;
	logic                wr_en;
	logic [NW-1:0]       wr_left, wr_right;
	logic                wr_holds;
	logic [SYM_W-1:0]    wr_sym;
	logic                out_busy;

	assign in_bits = s_tdata[BITS_W-1:0];
	assign in_len  = s_tdata[BITS_W +: LEN_IN_W];
	assign in_sym  = s_tdata[BITS_W+LEN_IN_W +: SYM_W];

	assign len_sat = (32'(in_len) > 32'(MAX_CODE_LENGTH)) ? LW'(MAX_CODE_LENGTH)
	                                                      : LW'(in_len);

	assign start_node = (command == CMD_INSERT) ? '0 : cur_node_q;
	assign link       = bits_q[0] ? w_right_q : w_left_q;
	assign free_idx   = free_q[NW-1:0];
	assign full       = (free_q == (NW+1)'(NODE_COUNT));
	assign out_busy   = out_valid_q && !m_tready;

	assign stat.cmd      = cmd_q;
	assign stat.len_zero = (len_q == '0);
	assign stat.link_nz  = (link != '0);
	assign stat.full     = full;
	assign stat.holds    = w_holds_q;
	assign stat.at_child = at_child_q;
	assign stat.out_busy = out_busy;

	// write data for the node under work
	assign wr_en    = ctl.alloc | ctl.store_leaf | ctl.write_back;
	assign wr_left  = (ctl.alloc && !bits_q[0]) ? free_idx : w_left_q;
	assign wr_right = (ctl.alloc &&  bits_q[0]) ? free_idx : w_right_q;
	assign wr_holds = ctl.store_leaf | w_holds_q;
	assign wr_sym   = ctl.store_leaf ? sym_q : w_sym_q;

	assign rd_addr = ctl.start ? start_node : link;

	// node table, registered read
	always_ff @(posedge clk) begin
		if (wr_en && (node_q != '0)) begin
			mem[node_q] <= {wr_sym, wr_holds, wr_right, wr_left};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_left_q  <= '0;
			root_right_q <= '0;
			root_holds_q <= 1'b0;
		end else if (wr_en && (node_q == '0)) begin
			root_left_q  <= wr_left;
			root_right_q <= wr_right;
			root_holds_q <= wr_holds;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (node_q == '0)) begin
			root_sym_q <= wr_sym;
		end
	end

	// walk control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q      <= CMD_IGNORE;
			at_child_q <= 1'b0;
			node_q     <= '0;
			cur_node_q <= '0;
			free_q     <= (NW+1)'(1);
		end else begin
			if (ctl.start) begin
				cmd_q      <= command;
				at_child_q <= 1'b0;
				node_q     <= start_node;
			end
			if (ctl.follow) begin
				node_q     <= link;
				at_child_q <= 1'b1;
			end
			if (ctl.alloc) begin
				node_q <= free_idx;
				free_q <= free_q + (NW+1)'(1);
			end
			if (ctl.cur_to_root) begin
				cur_node_q <= '0;
			end else if (ctl.cur_to_node) begin
				cur_node_q <= node_q;
			end
		end
	end

	// payload of the walk
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			bits_q <= in_bits;
			len_q  <= len_sat;
			sym_q  <= in_sym;
		end else if (ctl.follow || ctl.alloc) begin
			bits_q <= bits_q >> 1;
			len_q  <= len_q - LW'(1);
		end
		if (ctl.load) begin
			if (node_q == '0) begin
				w_left_q  <= root_left_q;
				w_right_q <= root_right_q;
				w_holds_q <= root_holds_q;
				w_sym_q   <= root_sym_q;
			end else begin
				{w_sym_q, w_holds_q, w_right_q, w_left_q} <= rd_q;
			end
		end else if (ctl.alloc) begin
			// fresh node: no children, no symbol
			w_left_q  <= '0;
			w_right_q <= '0;
			w_holds_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit_sym || ctl.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_sym || ctl.emit_err) begin
			out_err_q <= ctl.emit_err;
			out_sym_q <= ctl.emit_err ? '0 : w_sym_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sym_q;
	assign m_tuser  = out_err_q;

	`ASSERT_IMPL(a_free_range, 1'b1, (free_q >= (NW+1)'(1)) && (free_q <= (NW+1)'(NODE_COUNT)))
	`ASSERT_IMPL(a_no_alloc_full, ctl.alloc, !full)
	`ASSERT_IMPL(a_emit_slot_free, ctl.emit_sym || ctl.emit_err, !out_busy)
	`ASSERT_NEXT(a_fresh_node_empty, ctl.alloc, (w_left_q == '0) && (w_right_q == '0) && !w_holds_q)

endmodule
`default_nettype wire

// ----- sv/huffman_tree_decoder.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// huffman_tree_decoder
// Code-tree decoder: builds a prefix-code tree from insert words and walks
// it one code bit per decode word.
// ---------------------------------------------------------------------------
// Input stream: s_tuser carries the command (insert, decode bit, flush);
// s_tdata carries code_bits, code_length and symbol. Output stream: m_tdata
// is the decoded symbol, m_tuser flags a full node table on insert (symbol
// then reads zero). Successful inserts and decode bits that land on an
// inner node give no output word.
// Timing is set by the registered read port of the node table: each node
// read from the table passes through a load state before it is examined.
// One word is in flight at a time; s_tready is high only when idle.
// Results sit in an output register, so a new word is taken while an
// earlier result still waits. If the receiver stalls and a second result
// is due, the walk holds in place until the register frees.
// Reset clears the root node, sets the allocator to node one and puts the
// decode position at the root. Nodes beyond the root need no clearing:
// each is written when allocated, before it can be reached.
// ---------------------------------------------------------------------------
module huffman_tree_decoder #(
	parameter int NODE_COUNT      = hufd_pkg::NODE_COUNT_DEF,
	parameter int MAX_CODE_LENGTH = hufd_pkg::MAX_CODE_LENGTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// slave side
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [hufd_pkg::S_DATA_W-1:0] s_tdata,  // code_bits[15:0], code_length[20:16], symbol[28:21], zero
	input  wire logic [hufd_pkg::CMD_W-1:0]    s_tuser,  // command[1:0]
	// master side
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [hufd_pkg::SYM_W-1:0]         m_tdata,  // decoded_symbol[7:0]
	output logic                               m_tuser   // status[0]
);
	import hufd_pkg::*;

	cmd_t     command;
	ctl_cmd_t ctl;
	dp_stat_t stat;

	assign command = cmd_t'(s_tuser);

	// sequencer
	hufd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.command  (command),
		.s_tready (s_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// node table and walk registers
	hufd_datapath #(
		.NODE_COUNT      (NODE_COUNT),
		.MAX_CODE_LENGTH (MAX_CODE_LENGTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.command  (command),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
